// ----- hdl/packet_delay_drop_emulator_defines.svh -----
// Assertion macros for the checker file of this block.
`ifndef PACKET_DELAY_DROP_EMULATOR_DEFINES_SVH
`define PACKET_DELAY_DROP_EMULATOR_DEFINES_SVH

// Property checked on every rising edge outside of reset.
`define PDDE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define PDDE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/pdde_pkg.sv -----
package pdde_pkg;

  // Table geometry.
  localparam int PENDING_DEPTH = 16;
  localparam int MAX_RESULTS   = 16;
  localparam int IDX_W         = $clog2(PENDING_DEPTH);
  localparam int CNT_W         = $clog2(PENDING_DEPTH + 1);
  localparam int NRES_W        = $clog2(MAX_RESULTS + 1);

  // Field widths.
  localparam int HANDLE_W   = 16;
  localparam int CHANNEL_W  = 8;
  localparam int REM_W      = 17;
  localparam int THR_W      = 17;
  localparam int BASE_W     = 16;
  localparam int JITTER_W   = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // Command codes.
  localparam logic CMD_SEND = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DROP_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LATENCY_BASE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LATENCY_JITTER = 2'd2;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_FORWARD  = 2'd0,
    ST_RELEASED = 2'd1,
    ST_LOST     = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic                 cmd;
    logic [HANDLE_W-1:0]  packet_handle;
    logic [CHANNEL_W-1:0] channel_num;
    logic                 reliable;
    logic [15:0]          rand_drop;
    logic [15:0]          rand_jitter;
    logic [15:0]          elapsed;
  } in_item_t;

  typedef struct packed {
    logic [HANDLE_W-1:0]  out_handle;
    logic [CHANNEL_W-1:0] out_channel;
    status_t              status;
    logic                 last;
  } out_item_t;

  // One pending table entry as stored in memory.
  typedef struct packed {
    logic [HANDLE_W-1:0]  handle;
    logic [CHANNEL_W-1:0] channel;
    logic [REM_W-1:0]     remaining;
  } entry_t;

endpackage

// ----- hdl/pdde_ram.sv -----
module pdde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Single write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read; data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/packet_delay_drop_emulator.sv -----
// Send: a reliable, lost or table-full packet is reported from S_SEND once the result
// slot is free, which frees the input; a queued packet goes through S_SEND (product),
// then S_INS (table write). Tick: S_WALK reads the entries through the single read port
// of the table memory, then S_FLUSH; a busy result channel stalls it. One item at a time.
// Reset (synchronous, rst_n low) clears the control and configuration registers and the
// output valid; the table memory is not cleared, since only entries below the count are read.
module packet_delay_drop_emulator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  pdde_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output pdde_pkg::out_item_t                 out_data,
  input  logic                                cfg_wr_en,
  input  logic [pdde_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pdde_pkg::CFG_DATA_W-1:0]     cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SEND  = 5'b00010,
    S_INS   = 5'b00100,
    S_WALK  = 5'b01000,
    S_FLUSH = 5'b10000
  } state_t;

  localparam int CW = pdde_pkg::CNT_W;
  localparam int NW = pdde_pkg::NRES_W;
  localparam int IW = pdde_pkg::IDX_W;

  // Configuration registers.
  logic [pdde_pkg::THR_W-1:0]    drop_thr_r;
  logic [pdde_pkg::BASE_W-1:0]   base_r;
  logic [pdde_pkg::JITTER_W-1:0] jitter_r;

  // Control and payload registers.
  state_t                         state_r, state_nxt;
  pdde_pkg::in_item_t             item_r, item_nxt;
  logic [CW-1:0]                  cnt_r, cnt_nxt;
  logic [CW-1:0]                  rd_r, rd_nxt;
  logic [CW-1:0]                  wr_r, wr_nxt;
  logic [NW-1:0]                  n_r, n_nxt;
  logic                           ev_r, ev_nxt;
  logic                           hold_v_r, hold_v_nxt;
  logic [pdde_pkg::HANDLE_W-1:0]  hold_handle_r, hold_handle_nxt;
  logic [pdde_pkg::CHANNEL_W-1:0] hold_chan_r, hold_chan_nxt;
  logic [31:0]                    prod_r, prod_nxt;
  logic                           out_valid_r, out_valid_nxt;
  pdde_pkg::out_item_t            out_data_r, out_data_nxt;

  // Table memory ports.
  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  pdde_pkg::entry_t    ram_wdata;
  logic                ram_re;
  logic [IW-1:0]       ram_raddr;
  pdde_pkg::entry_t    ram_rdata;

  // Decision signals.
  logic                           slot_free;
  logic                           is_lost;
  logic                           is_full;
  logic                           due;
  logic                           emit_now;
  logic                           advance;
  logic                           more;
  logic                           issue;
  logic [pdde_pkg::REM_W:0]       delay_sum;
  logic [pdde_pkg::REM_W-1:0]     ins_rem;
  logic [pdde_pkg::REM_W-1:0]     kept_rem;
  logic [15:0]                    span;

  pdde_ram #(
    .WIDTH($bits(pdde_pkg::entry_t)),
    .DEPTH(pdde_pkg::PENDING_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Send decisions.
  assign slot_free = !out_valid_r || out_ready;
  assign is_lost   = {1'b0, item_r.rand_drop} < drop_thr_r;
  assign is_full   = cnt_r == CW'(pdde_pkg::PENDING_DEPTH);
  assign span      = {jitter_r, 1'b1};

  // Delay of a queued packet, clamped at zero.
  assign delay_sum = (pdde_pkg::REM_W + 1)'(base_r) + (pdde_pkg::REM_W + 1)'(prod_r[31:16])
                   - (pdde_pkg::REM_W + 1)'(jitter_r);
  assign ins_rem   = delay_sum[pdde_pkg::REM_W] ? '0 : delay_sum[pdde_pkg::REM_W-1:0];

  // Evaluation of the entry whose read data is present.
  assign due      = {1'b0, item_r.elapsed} >= ram_rdata.remaining;
  assign kept_rem = due ? '0 : ram_rdata.remaining - pdde_pkg::REM_W'(item_r.elapsed);
  assign emit_now = due && (n_r < NW'(pdde_pkg::MAX_RESULTS));
  assign advance  = ev_r && !(emit_now && hold_v_r && !slot_free);
  assign more     = rd_r < cnt_r;
  assign issue    = (state_r == S_WALK) && (!ev_r || advance) && more;

  // Next-state logic.
  always_comb begin
    state_nxt       = state_r;
    item_nxt        = item_r;
    cnt_nxt         = cnt_r;
    rd_nxt          = rd_r;
    wr_nxt          = wr_r;
    n_nxt           = n_r;
    ev_nxt          = ev_r;
    hold_v_nxt      = hold_v_r;
    hold_handle_nxt = hold_handle_r;
    hold_chan_nxt   = hold_chan_r;
    prod_nxt        = prod_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_data_nxt    = out_data_r;
    in_ready        = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = wr_r[IW-1:0];
    ram_wdata       = '{handle: ram_rdata.handle, channel: ram_rdata.channel,
                        remaining: kept_rem};
    ram_re          = 1'b0;
    ram_raddr       = rd_r[IW-1:0];

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_nxt = in_data;
          if (in_data.cmd == pdde_pkg::CMD_TICK) begin
            rd_nxt     = '0;
            wr_nxt     = '0;
            n_nxt      = '0;
            ev_nxt     = 1'b0;
            hold_v_nxt = 1'b0;
            state_nxt  = S_WALK;
          end else begin
            state_nxt = S_SEND;
          end
        end
      end

      // Reliable, lost or full packets report once the result slot is free; others go to the multiplier.
      S_SEND: begin
        if (item_r.reliable || is_lost || is_full) begin
          if (slot_free) begin
            out_valid_nxt           = 1'b1;
            out_data_nxt.out_handle  = item_r.packet_handle;
            out_data_nxt.out_channel = item_r.channel_num;
            out_data_nxt.last        = 1'b1;
            if (item_r.reliable) begin
              out_data_nxt.status = pdde_pkg::ST_FORWARD;
            end else if (is_lost) begin
              out_data_nxt.status = pdde_pkg::ST_LOST;
            end else begin
              out_data_nxt.status = pdde_pkg::ST_FULL;
            end
            state_nxt = S_IDLE;
          end
        end else begin
          prod_nxt  = {16'b0, span} * {16'b0, item_r.rand_jitter};
          state_nxt = S_INS;
        end
      end

      // Append the packet at the end of the table.
      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r[IW-1:0];
        ram_wdata = '{handle: item_r.packet_handle, channel: item_r.channel_num,
                      remaining: ins_rem};
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = S_IDLE;
      end

      // Walk the table: read ahead one entry, release or compact each entry.
      S_WALK: begin
        if (advance) begin
          if (emit_now) begin
            if (hold_v_r) begin
              out_valid_nxt            = 1'b1;
              out_data_nxt.out_handle  = hold_handle_r;
              out_data_nxt.out_channel = hold_chan_r;
              out_data_nxt.status      = pdde_pkg::ST_RELEASED;
              out_data_nxt.last        = 1'b0;
            end
            hold_v_nxt      = 1'b1;
            hold_handle_nxt = ram_rdata.handle;
            hold_chan_nxt   = ram_rdata.channel;
            n_nxt           = n_r + NW'(1);
          end else begin
            ram_we = 1'b1;
            wr_nxt = wr_r + CW'(1);
          end
        end
        if (issue) begin
          ram_re = 1'b1;
          rd_nxt = rd_r + CW'(1);
          ev_nxt = 1'b1;
        end else if (advance) begin
          ev_nxt = 1'b0;
        end
        if ((!ev_r || advance) && !more) begin
          state_nxt = S_FLUSH;
        end
      end

      // Commit the new count and send the final release with its last flag.
      S_FLUSH: begin
        cnt_nxt = wr_r;
        if (hold_v_r) begin
          if (slot_free) begin
            out_valid_nxt            = 1'b1;
            out_data_nxt.out_handle  = hold_handle_r;
            out_data_nxt.out_channel = hold_chan_r;
            out_data_nxt.status      = pdde_pkg::ST_RELEASED;
            out_data_nxt.last        = 1'b1;
            hold_v_nxt               = 1'b0;
            state_nxt                = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      rd_r        <= '0;
      wr_r        <= '0;
      n_r         <= '0;
      ev_r        <= 1'b0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_r        <= rd_nxt;
      wr_r        <= wr_nxt;
      n_r         <= n_nxt;
      ev_r        <= ev_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    item_r        <= item_nxt;
    hold_handle_r <= hold_handle_nxt;
    hold_chan_r   <= hold_chan_nxt;
    prod_r        <= prod_nxt;
    out_data_r    <= out_data_nxt;
  end

  // Configuration writes; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_thr_r <= '0;
      base_r     <= '0;
      jitter_r   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        pdde_pkg::REG_DROP_THRESHOLD: drop_thr_r <= cfg_data[pdde_pkg::THR_W-1:0];
        pdde_pkg::REG_LATENCY_BASE:   base_r     <= cfg_data[pdde_pkg::BASE_W-1:0];
        pdde_pkg::REG_LATENCY_JITTER: jitter_r   <= cfg_data[pdde_pkg::JITTER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hdl/pdde_checker.sv -----
`include "packet_delay_drop_emulator_defines.svh"

module pdde_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input pdde_pkg::out_item_t out_data
);

  logic out_stall;
  logic in_xfer;
  logic send_res;

  // Short names for the handshake conditions used below.
  assign out_stall = out_valid && !out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign send_res  = out_valid && (out_data.status != pdde_pkg::ST_RELEASED);

  // A stalled result transfer keeps its payload.
  `PDDE_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(out_data), "stalled result changed")

  // Reset leaves no result pending.
  `PDDE_ASSERT_ALWAYS(a_out_reset, !rst_n |=> !out_valid, "result valid right after reset")

  // One item is worked on at a time: an input transfer closes the input side.
  `PDDE_ASSERT(a_one_item, in_xfer |=> !in_ready, "input ready right after a transfer")

  // A send gives a single result, so every non-release status closes its item.
  `PDDE_ASSERT(a_single_last, send_res |-> out_data.last, "send result without last flag")

endmodule

bind packet_delay_drop_emulator pdde_checker u_pdde_checker (.*);

// ----- bench/packet_delay_drop_emulator_tb.sv -----
module packet_delay_drop_emulator_tb;
  import pdde_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int PHASE_ITEMS    = 46;
  localparam int PRESSURE_AT    = 23;
  localparam int MAX_SHOWN      = 10;

  // Index past the register list; writes to it must have no effect.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  // Mirrors the pending table and turns each accepted transfer into the
  // list of results the block owes for it.
  class emulator_tracker;
    logic [THR_W-1:0]     drop_thr = '0;
    logic [BASE_W-1:0]    base     = '0;
    logic [JITTER_W-1:0]  jitter   = '0;
    logic [HANDLE_W-1:0]  held_handle [PENDING_DEPTH];
    logic [CHANNEL_W-1:0] held_channel [PENDING_DEPTH];
    logic [REM_W-1:0]     held_wait [PENDING_DEPTH];
    int                   held_count = 0;
    out_item_t            reports_due [$];
    int faults = 0;
    int transfers_in = 0;
    int checked = 0;
    int forwarded = 0;
    int released = 0;
    int lost = 0;
    int full_drops = 0;

    function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DROP_THRESHOLD: drop_thr = data[THR_W-1:0];
        REG_LATENCY_BASE:   base     = data[BASE_W-1:0];
        REG_LATENCY_JITTER: jitter   = data[JITTER_W-1:0];
        default: ;
      endcase
    endfunction

    function int outstanding();
      return reports_due.size();
    endfunction

    // Append one owed result at the tail of the queue.
    function void owe_report(input out_item_t r);
      reports_due.insert(reports_due.size(), r);
    endfunction

    function void note_transfer(input in_item_t it);
      out_item_t   r;
      logic [31:0] scaled;
      int          delay;
      int          i;
      int          keep;
      int          n;
      transfers_in++;
      r.out_handle  = it.packet_handle;
      r.out_channel = it.channel_num;
      r.last        = 1'b1;
      if (it.cmd == CMD_SEND) begin
        // Reliable bypasses everything; the loss test comes before the full test.
        if (it.reliable) begin
          r.status = ST_FORWARD;
          owe_report(r);
          forwarded++;
        end else if ({1'b0, it.rand_drop} < drop_thr) begin
          r.status = ST_LOST;
          owe_report(r);
          lost++;
        end else if (held_count >= PENDING_DEPTH) begin
          r.status = ST_FULL;
          owe_report(r);
          full_drops++;
        end else begin
          scaled = ((32'(jitter) * 2 + 1) * 32'(it.rand_jitter)) >> 16;
          delay  = int'(base) + int'(scaled) - int'(jitter);
          if (delay < 0) begin
            delay = 0;
          end
          held_handle[held_count]  = it.packet_handle;
          held_channel[held_count] = it.channel_num;
          held_wait[held_count]    = REM_W'(delay);
          held_count++;
        end
      end else begin
        // A tick ages every entry and releases the due ones, up to MAX_RESULTS, in arrival order.
        keep = 0;
        n    = 0;
        for (i = 0; i < held_count; i++) begin
          if ({1'b0, it.elapsed} >= held_wait[i] && n < MAX_RESULTS) begin
            r.out_handle  = held_handle[i];
            r.out_channel = held_channel[i];
            r.status      = ST_RELEASED;
            r.last        = 1'b0;
            owe_report(r);
            released++;
            n++;
          end else begin
            held_handle[keep]  = held_handle[i];
            held_channel[keep] = held_channel[i];
            held_wait[keep]    = ({1'b0, it.elapsed} >= held_wait[i]) ? '0 :
                                 held_wait[i] - {1'b0, it.elapsed};
            keep++;
          end
        end
        held_count = keep;
        if (n > 0) begin
          r      = reports_due[reports_due.size() - 1];
          r.last = 1'b1;
          reports_due[reports_due.size() - 1] = r;
        end
      end
    endfunction

    function void check_report(input out_item_t got);
      out_item_t want;
      checked++;
      if (reports_due.size() == 0) begin
        faults++;
        if (faults <= MAX_SHOWN) begin
          $display("unexpected result: handle %h channel %h status %0d last %b",
                   got.out_handle, got.out_channel, got.status, got.last);
        end
        return;
      end
      want = reports_due.pop_front();
      if (got.out_handle !== want.out_handle || got.out_channel !== want.out_channel ||
          got.status !== want.status || got.last !== want.last) begin
        faults++;
        if (faults <= MAX_SHOWN) begin
          $display("mismatch: expected handle %h channel %h status %0d last %b",
                   want.out_handle, want.out_channel, want.status, want.last);
          $display("          got      handle %h channel %h status %0d last %b",
                   got.out_handle, got.out_channel, got.status, got.last);
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  emulator_tracker tracker = new;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  // Register settings and pacing for the random phases.
  int unsigned phase_thr [4]  = '{16384, 0, 1000, 40000};
  int unsigned phase_base [4] = '{20, 65535, 0, 300};
  int unsigned phase_jit [4]  = '{15, 32767, 100, 200};
  int          phase_send [4] = '{0, 58, 0, 33};
  int          phase_stall [4] = '{0, 0, 58, 33};

  packet_delay_drop_emulator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random back-pressure, and every transfer goes to the checker.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      tracker.check_report(out_data);
    end
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Watchdog: give up when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic in_item_t make_send(input logic [15:0] handle, input logic [7:0] chan,
                                         input logic rel, input logic [15:0] rdrop,
                                         input logic [15:0] rjit);
    in_item_t it;
    it.cmd           = CMD_SEND;
    it.packet_handle = handle;
    it.channel_num   = chan;
    it.reliable      = rel;
    it.rand_drop     = rdrop;
    it.rand_jitter   = rjit;
    it.elapsed       = 16'($urandom);
    return it;
  endfunction

  // Tick with random filler in the fields that a tick does not use.
  function automatic in_item_t make_tick(input logic [15:0] elapsed);
    in_item_t it;
    it.cmd           = CMD_TICK;
    it.packet_handle = 16'($urandom);
    it.channel_num   = 8'($urandom);
    it.reliable      = 1'($urandom_range(0, 1));
    it.rand_drop     = 16'($urandom);
    it.rand_jitter   = 16'($urandom);
    it.elapsed       = elapsed;
    return it;
  endfunction

  // Mostly sends, with tick lengths scaled to the current delay setting.
  function automatic in_item_t random_item(input int unsigned span);
    logic [15:0] elapsed;
    case ($urandom_range(0, 9))
      0, 1:    elapsed = 16'($urandom_range(0, 3));
      2:       elapsed = 16'($urandom);
      default: elapsed = 16'($urandom_range(0, span));
    endcase
    if ($urandom_range(0, 99) < 55) begin
      return make_send(16'($urandom), 8'($urandom), ($urandom_range(0, 3) == 0),
                       16'($urandom), 16'($urandom));
    end
    return make_tick(elapsed);
  endfunction

  // Offer one item, with a random gap first, and hold it until the transfer.
  task automatic push_item(input in_item_t it);
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_transfer(it);
  endtask

  // Stop sending until every owed result has come, then wait out the table walk.
  task automatic settle(input int quiet);
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.outstanding() != 0);
    repeat (quiet) @(posedge clk);
  endtask

  // Write all registers while idle; spare upper bits and the unmapped index carry junk.
  task automatic apply_setting(input logic [THR_W-1:0] thr, input logic [BASE_W-1:0] base,
                               input logic [JITTER_W-1:0] jit);
    logic [31:0]           junk;
    logic [CFG_DATA_W-1:0] word;
    settle(SETTLE_CYCLES);
    junk = $urandom;
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_DROP_THRESHOLD;
    cfg_data  <= thr;
    tracker.write_reg(REG_DROP_THRESHOLD, thr);
    @(posedge clk);
    word = {junk[0], base};
    cfg_index <= REG_LATENCY_BASE;
    cfg_data  <= word;
    tracker.write_reg(REG_LATENCY_BASE, word);
    @(posedge clk);
    word = {junk[2:1], jit};
    cfg_index <= REG_LATENCY_JITTER;
    cfg_data  <= word;
    tracker.write_reg(REG_LATENCY_JITTER, word);
    @(posedge clk);
    word = junk[20:4];
    cfg_index <= REG_UNMAPPED;
    cfg_data  <= word;
    tracker.write_reg(REG_UNMAPPED, word);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int          i;
    int          p;
    int unsigned span;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Zero delay: queued packets leave on the next tick, even with nothing elapsed.
    apply_setting(17'd0, 16'd0, 15'd0);
    push_item(make_send(16'hFFFF, 8'hFF, 1'b1, 16'h0000, 16'h0000));
    push_item(make_send(16'h0000, 8'h00, 1'b1, 16'hFFFF, 16'hFFFF));
    push_item(make_send(16'h0001, 8'h80, 1'b0, 16'h0000, 16'hFFFF));
    push_item(make_tick(16'h0000));
    push_item(make_tick(16'hFFFF));

    // Threshold above every draw: all unreliable packets are lost.
    apply_setting(17'h10000, 16'd5, 15'd3);
    push_item(make_send(16'hA5A5, 8'h5A, 1'b0, 16'hFFFF, 16'h1234));
    push_item(make_send(16'h5A5A, 8'hA5, 1'b1, 16'h0000, 16'h0000));

    // Widest jitter: alternate clamped and longest delays until the table is full.
    apply_setting(17'h08000, 16'd10, 15'h7FFF);
    for (i = 0; i < PENDING_DEPTH; i++) begin
      push_item(make_send(16'(16'h1000 + i), 8'(i * 17), 1'b0, 16'(16'h8000 + i * 2048),
                          (i % 2 == 0) ? 16'h0000 : 16'hFFFF));
    end
    push_item(make_send(16'hBEEF, 8'h3C, 1'b0, 16'hFFFF, 16'h0000));
    push_item(make_send(16'hCAFE, 8'hC3, 1'b0, 16'h0000, 16'h0000));
    push_item(make_tick(16'h0000));
    push_item(make_tick(16'hFFFF));
    push_item(make_tick(16'h0001));

    // Random phases, each with its own setting and pacing.
    for (p = 0; p < 4; p++) begin
      apply_setting(THR_W'(phase_thr[p]), BASE_W'(phase_base[p]), JITTER_W'(phase_jit[p]));
      send_idle_pct = phase_send[p];
      stall_pct     = phase_stall[p];
      span = (phase_base[p] + phase_jit[p]) / 3 + 1;
      if (span > 65535) begin
        span = 65535;
      end
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PRESSURE_AT) begin
          settle(0);
        end
        push_item(random_item(span));
      end
    end

    settle(SETTLE_CYCLES);
    $display("Covered %0d transfers in and %0d results over seven register settings",
             tracker.transfers_in, tracker.checked);
    $display("and four pacing mixes: %0d forwarded, %0d released, %0d lost, %0d table full.",
             tracker.forwarded, tracker.released, tracker.lost, tracker.full_drops);
    if (tracker.faults == 0 && tracker.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
